@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: operation kinds, result
// status codes, cell commands, chain status and the control state.
// ----------------------------------------------------------------------------
package deq_pkg;

   // operation kinds carried by an input item
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_LIST       = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int WORD_W = 32;

   // command broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT,
      CELL_POP_BACK,
      CELL_ROTATE
   } cell_op_type;

   // occupancy flags of the chain
   typedef struct packed {
      logic empty;
      logic full;
   } chain_stat_type;

   // control state
   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

endpackage

@@ hw/rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel (req_kind, req_value) selects push front,
// push back, pop front, pop back or list. Results leave on the rsp_ channel
// (rsp_status, rsp_value_res, rsp_last) through one output register.
// Push and pop give one result in the cycle after the item is accepted, and the
// next item can be taken in that same cycle, so one item per cycle is
// sustained while the receiver keeps up. A list walks the chain by rotating
// it once per entry: it gives one result per stored entry, one per cycle,
// from the list state on, and blocks new items until the final result
// (rsp_last) is registered. The chain rotates only when a result can be
// registered, so a stalled receiver simply holds the block; nothing is
// lost. Kinds 5 to 7 are accepted and dropped without a result.
// Reset empties the queue and clears rsp_valid; the result payload and the
// stored words are not cleared, and neither is read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [WORD_W-1:0] rsp_value_res,
   output logic                     rsp_last
);

   localparam int CW = $clog2(DEPTH + 1);

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            left_ff, left_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               status_ff, status_in;
   logic signed [WORD_W-1:0] value_ff, value_in;
   logic                     last_ff, last_in;

   cell_op_type              op;
   logic signed [WORD_W-1:0] head_word;
   logic signed [WORD_W-1:0] tail_word;
   chain_stat_type           stat;
   logic                     out_free;
   logic                     accept;

   deq_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .new_word  (req_value),
      .head_word (head_word),
      .tail_word (tail_word),
      .stat      (stat)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // next state, chain command and result
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      op           = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     value_in     = '0;
                     last_in      = 1'b1;
                     if (stat.full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        status_in = STATUS_OK;
                        count_in  = count_ff + CW'(1);
                        op = (req_kind == KIND_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                           : CELL_PUSH_BACK;
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     last_in      = 1'b1;
                     if (stat.empty) begin
                        status_in = STATUS_EMPTY;
                        value_in  = '0;
                     end else begin
                        status_in = STATUS_OK;
                        count_in  = count_ff - CW'(1);
                        if (req_kind == KIND_POP_FRONT) begin
                           value_in = head_word;
                           op       = CELL_POP_FRONT;
                        end else begin
                           value_in = tail_word;
                           op       = CELL_POP_BACK;
                        end
                     end
                  end
                  KIND_LIST: begin
                     if (stat.empty) begin
                        rsp_valid_in = 1'b1;
                        status_in    = STATUS_EMPTY;
                        value_in     = '0;
                        last_in      = 1'b1;
                     end else begin
                        state_in = ST_LIST;
                        left_in  = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            // emit the head and rotate the chain by one entry
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               value_in     = head_word;
               last_in      = (left_ff == CW'(1));
               op           = CELL_ROTATE;
               left_in      = left_ff - CW'(1);
               if (left_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_res = value_ff;
   assign rsp_last      = last_ff;

endmodule

@@ hw/rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue chain. Holds a word and an occupied flag and moves
// data to or from its neighbors according to the broadcast command.
// ----------------------------------------------------------------------------
module deq_cell
   import deq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_op_type              op,
   input  logic signed [WORD_W-1:0] new_word,
   input  logic signed [WORD_W-1:0] head_word,
   input  logic signed [WORD_W-1:0] prev_word,
   input  logic                     prev_valid,
   input  logic signed [WORD_W-1:0] next_word,
   input  logic                     next_valid,
   output logic signed [WORD_W-1:0] word,
   output logic                     valid,
   output logic                     is_tail
);

   logic signed [WORD_W-1:0] word_ff, word_in;
   logic                     valid_ff, valid_in;

   assign word    = word_ff;
   assign valid   = valid_ff;
   assign is_tail = valid_ff && !next_valid;

   // next contents from the command and the neighbors
   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff;
      case (op)
         CELL_PUSH_FRONT: begin
            word_in  = prev_word;
            valid_in = prev_valid;
         end
         CELL_PUSH_BACK: begin
            if (!valid_ff && prev_valid) begin
               word_in  = new_word;
               valid_in = 1'b1;
            end
         end
         CELL_POP_FRONT: begin
            word_in  = next_word;
            valid_in = next_valid;
         end
         CELL_POP_BACK: begin
            if (valid_ff && !next_valid) begin
               valid_in = 1'b0;
            end
         end
         CELL_ROTATE: begin
            // occupied span turns by one: tail slot takes the old head
            if (next_valid) begin
               word_in = next_word;
            end else if (valid_ff) begin
               word_in = head_word;
            end
         end
         default: begin
         end
      endcase
   end

   // stored word, no reset needed
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // occupied flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ hw/rtl/deq_chain.sv @@
// ----------------------------------------------------------------------------
// deq_chain
// Row of queue cells, front at cell 0. Links the cells to their neighbors and
// gives the head word, the tail word and the occupancy flags.
// ----------------------------------------------------------------------------
module deq_chain
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_op_type              op,
   input  logic signed [WORD_W-1:0] new_word,
   output logic signed [WORD_W-1:0] head_word,
   output logic signed [WORD_W-1:0] tail_word,
   output chain_stat_type           stat
);

   logic signed [WORD_W-1:0] word   [DEPTH];
   logic                     valid  [DEPTH];
   logic                     is_tail[DEPTH];
   logic signed [WORD_W-1:0] prev_word [DEPTH];
   logic                     prev_valid[DEPTH];
   logic signed [WORD_W-1:0] next_word [DEPTH];
   logic                     next_valid[DEPTH];

   // neighbor links; the front cell sees the incoming word as its predecessor
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            prev_word[i]  = new_word;
            prev_valid[i] = 1'b1;
         end else begin
            prev_word[i]  = word[i-1];
            prev_valid[i] = valid[i-1];
         end
         if (i == DEPTH - 1) begin
            next_word[i]  = '0;
            next_valid[i] = 1'b0;
         end else begin
            next_word[i]  = word[i+1];
            next_valid[i] = valid[i+1];
         end
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      deq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .new_word   (new_word),
         .head_word  (word[0]),
         .prev_word  (prev_word[g]),
         .prev_valid (prev_valid[g]),
         .next_word  (next_word[g]),
         .next_valid (next_valid[g]),
         .word       (word[g]),
         .valid      (valid[g]),
         .is_tail    (is_tail[g])
      );
   end

   // tail word by and-or over the one-hot tail flags
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | (is_tail[i] ? word[i] : '0);
      end
   end

   assign head_word  = word[0];
   assign stat.empty = !valid[0];
   assign stat.full  = valid[DEPTH-1];

endmodule

@@ tb/double_ended_queue_checker.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches the req_ and rsp_ channels of the deque. Keeps its own ring of
// words, front slot and occupancy, works out the results of every accepted
// item and compares each accepted result field by field with the oldest one
// still waiting. Reports the number of failures and of results outstanding.
// ----------------------------------------------------------------------------
module double_ended_queue_checker
   import deq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [2:0]               req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [1:0]               rsp_status,
   input  logic signed [WORD_W-1:0] rsp_value_res,
   input  logic                     rsp_last,
   output int                       fail_count,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] word;
      logic                     last;
   } deq_result_type;

   // results still owed by the block, oldest first
   deq_result_type awaited_results[$];

   // mirror of the ring contents
   logic signed [WORD_W-1:0] ring_words [DEPTH];
   int                       front_slot;
   int                       stored_count;

   function automatic void owe_result(logic [1:0] status, logic signed [WORD_W-1:0] word,
                                      logic last);
      deq_result_type r;
      r.status = status;
      r.word   = word;
      r.last   = last;
      awaited_results.push_back(r);
   endfunction

   // apply one operation to the mirror and queue what it yields
   function automatic void apply_operation(logic [2:0] kind, logic signed [WORD_W-1:0] word);
      int slot;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (stored_count >= DEPTH) begin
               owe_result(STATUS_FULL, '0, 1'b1);
            end else begin
               if (kind == KIND_PUSH_FRONT) begin
                  front_slot = (front_slot + DEPTH - 1) % DEPTH;
                  ring_words[front_slot] = word;
               end else begin
                  ring_words[(front_slot + stored_count) % DEPTH] = word;
               end
               stored_count++;
               owe_result(STATUS_OK, '0, 1'b1);
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (stored_count == 0) begin
               owe_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (kind == KIND_POP_FRONT) begin
                  slot = front_slot;
                  front_slot = (front_slot + 1) % DEPTH;
               end else begin
                  slot = (front_slot + stored_count - 1) % DEPTH;
               end
               stored_count--;
               owe_result(STATUS_OK, ring_words[slot], 1'b1);
            end
         end
         KIND_LIST: begin
            if (stored_count == 0) begin
               owe_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (int i = 0; i < stored_count; i++) begin
                  owe_result(STATUS_OK, ring_words[(front_slot + i) % DEPTH],
                             (i == stored_count - 1));
               end
            end
         end
         default: ;
      endcase
   endfunction

   // results are checked before the item of the same edge is applied
   always @(posedge clock) begin
      deq_result_type want;
      if (reset) begin
         front_slot   = 0;
         stored_count = 0;
         fail_count   = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: rsp_status %0d rsp_value_res %0d rsp_last %0d",
                      rsp_status, rsp_value_res, rsp_last);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_value_res !== want.word) begin
                  $error("rsp_value_res mismatch: expected %0d, actual %0d",
                         want.word, rsp_value_res);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last mismatch: expected %0d, actual %0d",
                         want.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_operation(req_kind, req_value);
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

@@ tb/double_ended_queue_test.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives the deque with a short directed sequence (empty store, word extremes,
// both pushes and pops, listing, ignored kinds) and then random bursts that
// fill it past full, drain it past empty and mix all operations, with random
// gaps on both channels. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
   timeunit 1ns;
   timeprecision 1ps;
   import deq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int OP_TARGET      = 450;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [2:0]               req_kind;
   logic signed [WORD_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [1:0]               rsp_status;
   logic signed [WORD_W-1:0] rsp_value_res;
   logic                     rsp_last;
   int                       fail_count;
   int                       pending_count;

   int idle_pct     = 11;
   int stall_pct    = 11;
   int ops_sent     = 0;
   int stuck_cycles = 0;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_res (rsp_value_res),
      .rsp_last      (rsp_last)
   );

   double_ended_queue_checker #(.DEPTH(DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_value_res (rsp_value_res),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // give up when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // present one item, with a random gap first, and hold it until taken
   task automatic send_item(input logic [2:0] kind, input logic signed [WORD_W-1:0] word);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_value <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (kind <= KIND_LIST) ops_sent++;
   endtask

   // mostly random words, now and then an extreme
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(39))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_push();
      return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
   endfunction

   function automatic logic [2:0] pick_pop();
      return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
   endfunction

   // push past full, then list the whole store
   task automatic fill_burst();
      for (int i = 0; i < DEPTH + 2; i++) send_item(pick_push(), pick_word());
      send_item(KIND_LIST, pick_word());
   endtask

   initial begin
      int pick;
      int burst;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_kind  = KIND_PUSH_FRONT;
      req_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty store, extremes, both ends, ignored kinds
      send_item(KIND_LIST, 32'sh5a5a5a5a);
      send_item(KIND_POP_FRONT, -32'sd1);
      send_item(KIND_POP_BACK, 32'sh7fffffff);
      send_item(KIND_PUSH_BACK, 32'sh7fffffff);
      send_item(KIND_PUSH_FRONT, 32'sh80000000);
      send_item(KIND_PUSH_BACK, '0);
      send_item(KIND_PUSH_FRONT, -32'sd1);
      send_item(KIND_LIST, '0);
      send_item(3'd5, -32'sd1);
      send_item(3'd6, 32'sh12345678);
      send_item(3'd7, '0);
      send_item(KIND_POP_BACK, '0);
      send_item(KIND_POP_FRONT, '0);
      send_item(KIND_LIST, -32'sd1);
      send_item(KIND_POP_FRONT, '0);
      send_item(KIND_POP_BACK, '0);
      send_item(KIND_POP_BACK, '0);
      send_item(KIND_LIST, '0);

      // random bursts, a quiet stretch with no gaps in the middle
      fill_burst();
      while (ops_sent < OP_TARGET) begin
         if (ops_sent >= 200 && ops_sent < 300) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = 11;
            stall_pct = 11;
         end
         burst = $urandom_range(9);
         if (burst < 2) begin
            fill_burst();
         end else if (burst < 4) begin
            // pop past empty, then list
            for (int i = 0; i < DEPTH + 2; i++) send_item(pick_pop(), pick_word());
            send_item(KIND_LIST, pick_word());
         end else begin
            // mixed operations
            for (int i = 0; i < 10; i++) begin
               pick = $urandom_range(99);
               if (pick < 40)      send_item(pick_push(), pick_word());
               else if (pick < 75) send_item(pick_pop(), pick_word());
               else if (pick < 95) send_item(KIND_LIST, pick_word());
               else                send_item(3'($urandom_range(7, 5)), pick_word());
            end
         end
      end
      req_valid <= 1'b0;

      // let every owed result arrive, then idle before reporting
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
